// ===== hw/rtl/sorted_min_priority_queue_top_assert.svh =====
// Assertion macros used by the sorted minimum priority queue port checker.
`ifndef SORTED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Antecedent and consequent are checked in the same cycle.
`define SMPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/smpq_pkg.sv =====
// Shared types and constants of the sorted minimum priority queue.
package smpq_pkg;

    localparam int unsigned HANDLE_W  = 9;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned OCC_W     = 9;
    localparam int unsigned DEPTH_DEF = 256;

    // Stream widths, padded to whole bytes.
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_PAD_W   = M_TDATA_W - (OCC_W + KEY_W + HANDLE_W);

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } smpq_req_t;

    // One stored entry; the handle sits in the low bits.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } smpq_entry_t;

endpackage

// ===== hw/rtl/smpq_store.sv =====
// Entry memory of the priority queue: one write port, one registered read port.
module smpq_store #(
    parameter int unsigned DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  smpq_pkg::smpq_entry_t      wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output smpq_pkg::smpq_entry_t      rd_data
);
    import smpq_pkg::*;

    smpq_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/sorted_min_priority_queue_top.sv =====
// Top level of the sorted minimum priority queue.
//
// This block is a minimum priority queue of DEPTH entries, keyed on an unsigned
// 32-bit frequency, as used when building a Huffman tree. Each input transaction
// is an enqueue (tuser = 0) or a dequeue (tuser = 1), and each one produces
// exactly one output transaction that reports success in tuser and the
// occupancy after the request. Entries are held in ascending key order in a
// single ring-addressed memory; among equal keys the earlier arrival is served
// first. A dequeue returns the front entry: the head is read in ST_IDLE and the
// result is loaded in ST_DEQ. A dequeue that is refused (queue empty), an
// enqueue that is refused (queue full) and an enqueue into an empty queue load
// their result straight from ST_IDLE. An enqueue into a non-empty queue walks
// backward from the tail in ST_INS, moving each entry with a larger key one
// place up; as the memory has a single read and a single write port, each move
// is its own step. If every held entry moved, ST_PLACE writes the new entry at
// the head. One request is in work at a time, and its result sits in an output
// register. The next request is taken only when the block is idle and that
// register is empty or its transaction completes in the same cycle, so a
// stalled result holds off the input. No clearing pass follows reset.
module sorted_min_priority_queue_top #(
    parameter int unsigned DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // item_handle [8:0], item_key [40:9], zero pad [47:41]
    input  logic [smpq_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type [0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_handle [8:0], out_key [40:9], occupancy [49:41], zero pad [55:50]
    output logic [smpq_pkg::M_TDATA_W-1:0]   m_tdata,
    // ok [0]
    output logic [0:0]                       m_tuser
);
    import smpq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_PLACE,
        ST_DEQ
    } state_t;

    // Physical address of an offset from the head, wrapping at DEPTH.
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_A)
        begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          pos_reg, pos_next;
    smpq_entry_t            new_reg, new_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [0:0]             m_tuser_reg, m_tuser_next;

    // Memory port controls.
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    smpq_entry_t            wr_data;
    logic [AW-1:0]          rd_addr;
    smpq_entry_t            rd_data;

    // Input fields.
    smpq_req_t              in_req;
    smpq_entry_t            in_entry;
    logic                   accept;

    // Result to load into the output register.
    logic                   res_load;
    logic                   res_ok;
    smpq_entry_t            res_entry;
    logic [CW-1:0]          res_occ;

    assign in_req          = smpq_req_t'(s_tuser[0]);
    assign in_entry.handle = s_tdata[HANDLE_W-1:0];
    assign in_entry.key    = s_tdata[HANDLE_W+KEY_W-1:HANDLE_W];

    // A new request is taken only when the previous one is finished and its
    // result has left, or is leaving in this cycle.
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    smpq_store #(
        .DEPTH (DEPTH)
    ) u_smpq_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        new_next   = new_reg;

        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = new_reg;
        rd_addr    = head_reg;

        res_load   = 1'b0;
        res_ok     = 1'b0;
        res_entry  = '0;
        res_occ    = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_req == REQ_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            // Dequeue from an empty queue is refused.
                            res_load = 1'b1;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            state_next = ST_DEQ;
                        end
                    end
                    else if (count_reg == DEPTH_C)
                    begin
                        // Enqueue into a full queue is refused.
                        res_load = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg;
                        wr_data    = in_entry;
                        count_next = count_reg + 1'b1;
                        res_load   = 1'b1;
                        res_ok     = 1'b1;
                        res_occ    = count_next;
                    end
                    else
                    begin
                        // Start the backward walk at the tail entry.
                        rd_addr    = ring_addr(head_reg, AW'(count_reg - 1'b1));
                        pos_next   = AW'(count_reg);
                        new_next   = in_entry;
                        state_next = ST_INS;
                    end
                end
            end

            ST_INS:
            begin
                // rd_data holds the entry at offset pos_reg - 1.
                wr_en   = 1'b1;
                wr_addr = ring_addr(head_reg, pos_reg);
                if (rd_data.key > new_reg.key)
                begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - 1'b1;
                    if (pos_reg == AW'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rd_addr = ring_addr(head_reg, pos_reg - AW'(2));
                    end
                end
                else
                begin
                    wr_data    = new_reg;
                    count_next = count_reg + 1'b1;
                    res_load   = 1'b1;
                    res_ok     = 1'b1;
                    res_occ    = count_next;
                    state_next = ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                // Every held entry moved up; the new one becomes the front.
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                wr_data    = new_reg;
                count_next = count_reg + 1'b1;
                res_load   = 1'b1;
                res_ok     = 1'b1;
                res_occ    = count_next;
                state_next = ST_IDLE;
            end

            ST_DEQ:
            begin
                head_next  = ring_addr(head_reg, AW'(1));
                count_next = count_reg - 1'b1;
                res_load   = 1'b1;
                res_ok     = 1'b1;
                res_entry  = rd_data;
                res_occ    = count_next;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, OCC_W'(res_occ), res_entry};
            m_tuser_next  = res_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            new_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            new_reg      <= new_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

endmodule

// ===== hw/rtl/smpq_checker.sv =====
// Port-level checker for the sorted minimum priority queue, with its bind.
`include "sorted_min_priority_queue_top_assert.svh"

module smpq_port_checker #(
    parameter int unsigned DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [smpq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]                       m_tuser
);
    import smpq_pkg::*;

    localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

    logic [OCC_W-1:0] last_occ_reg;
    logic [OCC_W-1:0] occ;
    logic [OCC_W-1:0] occ_up;
    logic [OCC_W-1:0] occ_down;
    logic             ok;

    assign occ      = m_tdata[OCC_W+KEY_W+HANDLE_W-1:KEY_W+HANDLE_W];
    assign ok       = m_tuser[0];
    assign occ_up   = last_occ_reg + 1'b1;
    assign occ_down = last_occ_reg - 1'b1;

    // Occupancy reported by the most recent completed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_occ_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            last_occ_reg <= occ;
        end
    end

    `SMPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")
    `SMPQ_ASSERT_SAME(a_fail_zero, m_tvalid && !ok, m_tdata[KEY_W+HANDLE_W-1:0] == '0, "refused request carries an entry")
    `SMPQ_ASSERT_SAME(a_fail_edge, m_tvalid && !ok, occ == '0 || occ == DEPTH_OCC, "refusal while neither empty nor full")
    `SMPQ_ASSERT_SAME(a_occ_step, m_tvalid, ok ? (occ == occ_up || occ == occ_down) : (occ == last_occ_reg), "occupancy stepped wrongly")

endmodule

bind sorted_min_priority_queue_top smpq_port_checker #(
    .DEPTH (DEPTH)
) u_smpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
